>>> sv/dmx_fixture_slot_decoder_assert.svh
// assertion helpers for the slot decoder
`ifndef DMX_FIXTURE_SLOT_DECODER_ASSERT_SVH
`define DMX_FIXTURE_SLOT_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DFSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DFSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dfsd_pkg.sv
package dfsd_pkg;

  localparam int MAX_SLOTS   = 513;
  localparam int SLOT_W      = 10;
  localparam int ADDR_W      = 10;
  localparam int PERS_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int FOOTPRINT   = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSONALITY   = 2'd1;

  localparam logic [PERS_W-1:0] PERS_RGB_TIMING = 2'd1;

  localparam logic [ADDR_W-1:0] START_ADDR_RST = 10'd1;
  localparam logic [PERS_W-1:0] PERS_RST       = 2'd1;

  localparam logic [9:0]  BREAK_DEF = 10'd176;
  localparam logic [9:0]  BREAK_MIN = 10'd40;
  localparam logic [9:0]  BREAK_MAX = 10'd1000;
  localparam logic [8:0]  MAB_DEF   = 9'd12;
  localparam logic [8:0]  MAB_MIN   = 9'd12;
  localparam logic [11:0] TURN_DEF  = 12'd0;
  localparam logic [17:0] BAUD_DEF  = 18'd250000;
  localparam logic [17:0] BAUD_LO   = 18'd245000;
  localparam logic [17:0] BAUD_HI   = 18'd255000;
  localparam logic [7:0]  BAUD_MID  = 8'd128;

  // x*C/d as (x * C*ceil(2^S/d)) >> S, exact over the 8-bit control range
  localparam logic [27:0] K_BRK  = 28'd253640640;   // 960 * ceil(2^26/254)
  localparam logic [26:0] K_MAB  = 27'd128933992;   // 488 * ceil(2^26/254)
  localparam logic [31:0] K_TURN = 32'd3158067000;  // 3000 * ceil(2^28/255)
  localparam logic [31:0] K_BAUD = 32'd2642085000;  // 5000 * ceil(2^26/127)
  localparam int SH_BRK  = 26;
  localparam int SH_MAB  = 26;
  localparam int SH_TURN = 28;
  localparam int SH_BAUD = 26;

  typedef struct packed {
    logic [7:0] slot_value;
    logic       frame_start;
    logic       frame_end;
    logic       frame_good;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [9:0]  break_us;
    logic [8:0]  mab_us;
    logic [11:0] turn_us;
    logic [17:0] baud_rate;
    logic        rgb_updated;
    logic        timing_updated;
  } out_item_t;

  typedef struct packed {
    logic [FOOTPRINT-1:0][7:0] slots;
    logic                      rgb_ok;
    logic                      tim_ok;
  } frame_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> sv/dfsd_front.sv
module dfsd_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dfsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dfsd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dfsd_pkg::in_item_t                   in_data,
  input  dfsd_pkg::q_status_t                  q_status,
  output logic                                 push_valid,
  output dfsd_pkg::frame_cmd_t                 push_cmd
);

  logic [dfsd_pkg::ADDR_W-1:0]               start_addr_r;
  logic [dfsd_pkg::PERS_W-1:0]               pers_r;
  logic [dfsd_pkg::SLOT_W-1:0]               slot_count_r, slot_count_nxt;
  logic                                      scz_r, scz_nxt;
  logic [dfsd_pkg::FOOTPRINT-1:0][7:0]       shadow_r, shadow_nxt;

  logic                                      acc;
  logic [dfsd_pkg::SLOT_W-1:0]               idx, n, diff;
  logic                                      in_range, hit, commit_base;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_status.full;
  assign acc       = in_valid && in_ready;

  always_comb begin
    idx        = in_data.frame_start ? '0 : slot_count_r;
    in_range   = idx < dfsd_pkg::SLOT_W'(dfsd_pkg::MAX_SLOTS);
    n          = in_range ? idx + 1'b1 : dfsd_pkg::SLOT_W'(dfsd_pkg::MAX_SLOTS);
    diff       = idx - start_addr_r;
    hit        = in_range && (start_addr_r != '0) && (idx >= start_addr_r) &&
                 (diff < dfsd_pkg::SLOT_W'(dfsd_pkg::FOOTPRINT));
    shadow_nxt = shadow_r;
    if (hit) begin
      shadow_nxt[diff[2:0]] = in_data.slot_value;
    end
    scz_nxt = scz_r;
    if (in_range && (idx == '0)) begin
      scz_nxt = (in_data.slot_value == 8'd0);
    end
    slot_count_nxt = in_data.frame_end ? '0 : n;
    commit_base    = in_data.frame_good && scz_nxt && (start_addr_r != '0);
    push_cmd.slots  = shadow_nxt;
    push_cmd.rgb_ok = commit_base &&
                      (({1'b0, start_addr_r} + 11'd2) < {1'b0, n});
    push_cmd.tim_ok = commit_base && (pers_r == dfsd_pkg::PERS_RGB_TIMING) &&
                      (({1'b0, start_addr_r} + 11'd6) < {1'b0, n});
    push_valid      = acc && in_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= dfsd_pkg::START_ADDR_RST;
      pers_r       <= dfsd_pkg::PERS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dfsd_pkg::REG_START_ADDRESS: start_addr_r <= cfg_data;
        dfsd_pkg::REG_PERSONALITY:   pers_r <= cfg_data[dfsd_pkg::PERS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= '0;
      scz_r        <= 1'b0;
      shadow_r     <= '0;
    end else if (acc) begin
      slot_count_r <= slot_count_nxt;
      scz_r        <= scz_nxt;
      shadow_r     <= shadow_nxt;
    end
  end

endmodule

>>> sv/dfsd_queue.sv
module dfsd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  dfsd_pkg::frame_cmd_t push_cmd,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output dfsd_pkg::frame_cmd_t pop_cmd,
  output dfsd_pkg::q_status_t  q_status
);

  dfsd_pkg::frame_cmd_t           mem [dfsd_pkg::QUEUE_DEPTH];
  logic [dfsd_pkg::QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [dfsd_pkg::QUEUE_AW:0]    count_r, count_nxt;
  logic                           do_push, do_pop;

  assign q_status.full  = count_r == (dfsd_pkg::QUEUE_AW+1)'(dfsd_pkg::QUEUE_DEPTH);
  assign q_status.empty = count_r == '0;
  assign pop_valid      = !q_status.empty;
  assign pop_cmd        = mem[rd_ptr_r];
  assign do_push        = push_valid && !q_status.full;
  assign do_pop         = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> sv/dfsd_back.sv
module dfsd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  dfsd_pkg::frame_cmd_t pop_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dfsd_pkg::out_item_t  out_data
);

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        rgb_ok;
    logic        tim_ok;
    logic [35:0] prod_brk;
    logic [34:0] prod_mab;
    logic [39:0] prod_turn;
    logic [38:0] prod_baud;
    logic        brk_dflt;
    logic        mab_dflt;
    logic        baud_dflt;
    logic        baud_neg;
  } mul_stage_t;

  mul_stage_t           s1_r, s1_nxt;
  logic                 s1_valid_r;
  logic                 out_valid_r;
  dfsd_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                 adv2, s1_en;
  logic [7:0]           v_brk, v_mab, v_turn, v_baud, u_baud;
  logic [12:0]          q_baud;

  assign adv2      = !out_valid_r || out_ready;
  assign s1_en     = !s1_valid_r || adv2;
  assign pop_ready = s1_en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control values and constant-reciprocal products
  always_comb begin
    v_brk  = pop_cmd.slots[3];
    v_mab  = pop_cmd.slots[4];
    v_turn = pop_cmd.slots[5];
    v_baud = pop_cmd.slots[6];
    u_baud = (v_baud < dfsd_pkg::BAUD_MID) ? dfsd_pkg::BAUD_MID - v_baud
                                            : v_baud - dfsd_pkg::BAUD_MID;
    s1_nxt.red       = pop_cmd.slots[0];
    s1_nxt.green     = pop_cmd.slots[1];
    s1_nxt.blue      = pop_cmd.slots[2];
    s1_nxt.rgb_ok    = pop_cmd.rgb_ok;
    s1_nxt.tim_ok    = pop_cmd.tim_ok;
    s1_nxt.prod_brk  = 36'(v_brk - 8'd1) * 36'(dfsd_pkg::K_BRK);
    s1_nxt.prod_mab  = 35'(v_mab - 8'd1) * 35'(dfsd_pkg::K_MAB);
    s1_nxt.prod_turn = 40'(v_turn) * 40'(dfsd_pkg::K_TURN);
    s1_nxt.prod_baud = 39'(u_baud[6:0]) * 39'(dfsd_pkg::K_BAUD);
    s1_nxt.brk_dflt  = v_brk == 8'd0;
    s1_nxt.mab_dflt  = v_mab == 8'd0;
    s1_nxt.baud_dflt = v_baud == 8'd0;
    s1_nxt.baud_neg  = v_baud < dfsd_pkg::BAUD_MID;
  end

  // out_data_r doubles as the held state
  always_comb begin
    out_data_nxt = out_data_r;
    q_baud       = s1_r.prod_baud[dfsd_pkg::SH_BAUD +: 13];
    if (s1_r.rgb_ok) begin
      out_data_nxt.red   = s1_r.red;
      out_data_nxt.green = s1_r.green;
      out_data_nxt.blue  = s1_r.blue;
    end
    if (s1_r.tim_ok) begin
      out_data_nxt.break_us = s1_r.brk_dflt ? dfsd_pkg::BREAK_DEF :
        dfsd_pkg::BREAK_MIN + s1_r.prod_brk[dfsd_pkg::SH_BRK +: 10];
      out_data_nxt.mab_us = s1_r.mab_dflt ? dfsd_pkg::MAB_DEF :
        dfsd_pkg::MAB_MIN + s1_r.prod_mab[dfsd_pkg::SH_MAB +: 9];
      out_data_nxt.turn_us = s1_r.prod_turn[dfsd_pkg::SH_TURN +: 12];
      if (s1_r.baud_dflt) begin
        out_data_nxt.baud_rate = dfsd_pkg::BAUD_DEF;
      end else if (s1_r.baud_neg) begin
        out_data_nxt.baud_rate = dfsd_pkg::BAUD_DEF - 18'(q_baud);
      end else begin
        out_data_nxt.baud_rate = dfsd_pkg::BAUD_DEF + 18'(q_baud);
      end
    end
    out_data_nxt.rgb_updated    = s1_r.rgb_ok;
    out_data_nxt.timing_updated = s1_r.tim_ok;
  end

  always_ff @(posedge clk) begin
    if (s1_en && pop_valid) begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '{red: 8'd0, green: 8'd0, blue: 8'd0,
                       break_us: dfsd_pkg::BREAK_DEF, mab_us: dfsd_pkg::MAB_DEF,
                       turn_us: dfsd_pkg::TURN_DEF, baud_rate: dfsd_pkg::BAUD_DEF,
                       rgb_updated: 1'b0, timing_updated: 1'b0};
    end else begin
      if (s1_en) begin
        s1_valid_r <= pop_valid;
      end
      if (adv2) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          out_data_r <= out_data_nxt;
        end
      end
    end
  end

endmodule

>>> sv/dmx_fixture_slot_decoder.sv
// channel  dir  handshake               payload
// in       in   in_valid / in_ready     in_data (dfsd_pkg::in_item_t)
// out      out  out_valid / out_ready   out_data (dfsd_pkg::out_item_t)
// cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one slot transfer per cycle; in_ready drops only when the four-entry frame queue is full
// a frame-end transfer is queued at its own edge; its result moves via s1_r to out_data_r
// out_data_r holds while valid and out_ready is low; a full multiply stage stalls too
// reset is synchronous, active low; cfg_ready is always high
module dmx_fixture_slot_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dfsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dfsd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dfsd_pkg::out_item_t             out_data
);

`include "dmx_fixture_slot_decoder_assert.svh"

  logic                 push_valid;
  dfsd_pkg::frame_cmd_t push_cmd;
  logic                 pop_valid, pop_ready;
  dfsd_pkg::frame_cmd_t pop_cmd;
  dfsd_pkg::q_status_t  q_status;

  dfsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  dfsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .q_status   (q_status)
  );

  dfsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `DFSD_ASSERT_NEXT(a_end_queued, in_valid && in_ready && in_data.frame_end, !q_status.empty, "frame end transfer not queued")
  `DFSD_ASSERT_NOW(a_tim_needs_rgb, out_valid && out_data.timing_updated, out_data.rgb_updated, "timing commit without colour commit")
  `DFSD_ASSERT_NOW(a_break_range, out_valid, out_data.break_us >= dfsd_pkg::BREAK_MIN && out_data.break_us <= dfsd_pkg::BREAK_MAX, "break length out of range")
  `DFSD_ASSERT_NOW(a_baud_range, out_valid, out_data.baud_rate >= dfsd_pkg::BAUD_LO && out_data.baud_rate <= dfsd_pkg::BAUD_HI, "baud rate out of range")

endmodule
